// ----- src/sliding_window_trend_stats_top_assert.svh -----
// assertion macros for the trend statistics block
`ifndef SLIDING_WINDOW_TREND_STATS_TOP_ASSERT_SVH
`define SLIDING_WINDOW_TREND_STATS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SWTS_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SWTS_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define SWTS_ASSERT(name, prop)
`define SWTS_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ----- src/swts_pkg.sv -----
// shared constants and widths for the trend statistics block
package swts_pkg;
    localparam int SAMPLE_W    = 24;
    localparam int WIN_W       = 7;
    localparam int WINDOW_MAX  = 64;
    localparam int WIN_RESET   = 7;
    localparam int HIST_DEPTH  = WINDOW_MAX + 1;
    localparam int ADDR_W      = $clog2(HIST_DEPTH);
    localparam int SEEN_W      = 8;
    localparam int SEEN_MAX    = 255;
    localparam int PCT_W       = 16;
    localparam int CNT_W       = 16;
    localparam int PCT_SCALE   = 100;
    localparam int SUM_W       = SAMPLE_W + WIN_W;
    localparam int S_W         = SAMPLE_W + WIN_W;
    localparam int SQ1_W       = 2 * SAMPLE_W - 1;
    localparam int SQ_W        = SQ1_W + WIN_W;
    localparam int PSQ_W       = SQ_W + WIN_W;
    localparam int ROOT_W      = (PSQ_W + 3) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 3;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);
    localparam int A_W         = 32;
    localparam int DIV_W       = 34;
    localparam int DVS_W       = SAMPLE_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
endpackage

// ----- src/swts_in_if.sv -----
// request channel carrying one sample
interface swts_in_if;
    import swts_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ----- src/swts_out_if.sv -----
// result channel carrying the window statistics
interface swts_out_if;
    import swts_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_W-1:0]     increase_avg;
    logic                    increase_valid;
    logic signed [PCT_W-1:0] change_percent;
    logic                    change_valid;
    logic [SAMPLE_W-1:0]     deviation;
    logic                    deviation_valid;
    logic                    switch_now;
    logic [CNT_W-1:0]        switch_total;

    modport source (output valid, output increase_avg, output increase_valid,
                    output change_percent, output change_valid, output deviation,
                    output deviation_valid, output switch_now, output switch_total,
                    input ready);
    modport sink   (input valid, input increase_avg, input increase_valid,
                    input change_percent, input change_valid, input deviation,
                    input deviation_valid, input switch_now, input switch_total,
                    output ready);
endinterface

// ----- src/sliding_window_trend_stats_top.sv -----
// Sliding window trend statistics. One sample is taken per request; the block
// then stays busy (samples.ready low) while a sequencer walks the history ram
// once, runs a 32 step square root and up to three 34 step divisions on one
// shared divider (the percent change division only when a percent change is
// computed) and waits for room in a full output register; only then is the
// next request accepted. A finished result waits in the output register while
// the next sample is taken. The window register is written through wr_en /
// wr_data and applies to the next sample.
module sliding_window_trend_stats_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [swts_pkg::WIN_W-1:0] wr_data,
    swts_in_if.sink                    samples,
    swts_out_if.source                 results
);
    import swts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PASS, ST_MUL, ST_PREP, ST_SQRT,
        ST_DIVI_GO, ST_DIVI, ST_DIVC_GO, ST_DIVC, ST_DIVD_GO, ST_DIVD, ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [WIN_W-1:0]           win_reg;
    logic [ADDR_W-1:0]          wptr_reg;
    logic [SEEN_W-1:0]          seen_reg;
    logic [WIN_W-1:0]           p_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [WIN_W-1:0]           iss_reg;
    logic                       rd_vld_reg;
    logic [WIN_W-1:0]           rd_idx_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] now_reg;
    logic signed [SAMPLE_W-1:0] old_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic signed [S_W-1:0]      s_reg;
    logic [SQ1_W-1:0]           sq_prod_reg;
    logic                       sq_vld_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [PSQ_W-1:0]           psq_reg;
    logic [PSQ_W-1:0]           ssq_reg;
    logic [A_W-1:0]             a_reg;
    logic [SAMPLE_W-1:0]        b_reg;
    logic                       neg_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [DIV_W-1:0]           inc_q_reg;
    logic [DIV_W-1:0]           chg_q_reg;
    logic signed [PCT_W-1:0]    prev_chg_reg;
    logic [CNT_W-1:0]           swcnt_reg;
    logic                       out_vld_reg;
    logic [SAMPLE_W-1:0]        inc_out_reg;
    logic                       inc_ok_out_reg;
    logic signed [PCT_W-1:0]    chg_out_reg;
    logic                       chg_ok_out_reg;
    logic [SAMPLE_W-1:0]        dev_out_reg;
    logic                       dev_ok_out_reg;
    logic                       sw_out_reg;

    logic                       accept;
    logic [WIN_W-1:0]           p_clamp;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_val;
    logic signed [SAMPLE_W:0]   step_diff;
    logic signed [2*SAMPLE_W-1:0] sq_now;
    logic [S_W-1:0]             s_abs;
    logic signed [SAMPLE_W:0]   chg_diff;
    logic [SAMPLE_W:0]          diff_abs;
    logic                       inc_ok;
    logic                       dev_ok;
    logic                       chg_ok;
    logic                       sw;
    logic signed [PCT_W-1:0]    chg_val;
    logic [SAMPLE_W-1:0]        inc_val;
    logic [SAMPLE_W-1:0]        dev_val;
    logic                       sqrt_start;
    logic                       sqrt_done;
    logic [ROOT_W-1:0]          sqrt_root;
    logic [RAD_W-1:0]           radicand;
    logic                       div_start;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quo;
    logic [DIV_W-1:0]           dividend;
    logic [DVS_W-1:0]           divisor;

    assign accept = samples.valid && samples.ready;

    always_comb
    begin
        priority if (win_reg == '0)
            p_clamp = WIN_W'(1);
        else if (win_reg > WIN_W'(WINDOW_MAX))
            p_clamp = WIN_W'(WINDOW_MAX);
        else
            p_clamp = win_reg;
    end

    swts_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist (
        .clk   (clk),
        .we    (accept),
        .waddr (wptr_reg),
        .wdata (samples.sample),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    swts_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    swts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        rd_val    = $signed(ram_rdata);
        step_diff = {prev_reg[SAMPLE_W-1], prev_reg} - {rd_val[SAMPLE_W-1], rd_val};
        sq_now    = rd_val * rd_val;
        s_abs     = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);
        chg_diff  = {now_reg[SAMPLE_W-1], now_reg} - {old_reg[SAMPLE_W-1], old_reg};
        diff_abs  = chg_diff[SAMPLE_W] ? (SAMPLE_W+1)'(-chg_diff) : (SAMPLE_W+1)'(chg_diff);
        radicand  = RAD_W'({psq_reg - ssq_reg, 2'b00});
        sqrt_start = (state_reg == ST_PREP);
        div_start  = (state_reg == ST_DIVI_GO) || (state_reg == ST_DIVC_GO)
                  || (state_reg == ST_DIVD_GO);
        unique case (state_reg)
            ST_DIVC_GO, ST_DIVC:
            begin
                dividend = DIV_W'({a_reg, 1'b0}) + DIV_W'(b_reg);
                divisor  = DVS_W'({b_reg, 1'b0});
            end
            ST_DIVD_GO, ST_DIVD:
            begin
                dividend = DIV_W'(root_reg) + DIV_W'(p_reg);
                divisor  = DVS_W'({p_reg, 1'b0});
            end
            default:
            begin
                dividend = DIV_W'({sum_reg, 1'b0}) + DIV_W'(p_reg);
                divisor  = DVS_W'({p_reg, 1'b0});
            end
        endcase
    end

    // result assembly
    always_comb
    begin
        inc_ok = seen_reg > SEEN_W'(p_reg);
        dev_ok = seen_reg >= SEEN_W'(p_reg);
        chg_ok = inc_ok && (old_reg != '0);
        inc_val = (inc_q_reg > DIV_W'(24'hFFFFFF)) ? '1 : inc_q_reg[SAMPLE_W-1:0];
        dev_val = (div_quo > DIV_W'(24'hFFFFFF)) ? '1 : div_quo[SAMPLE_W-1:0];
        if (neg_reg)
            chg_val = (chg_q_reg > DIV_W'(32768)) ? PCT_W'(16'sh8000)
                                                 : -$signed(chg_q_reg[PCT_W-1:0]);
        else
            chg_val = (chg_q_reg > DIV_W'(32767)) ? PCT_W'(16'sh7FFF)
                                                 : $signed(chg_q_reg[PCT_W-1:0]);
        if (!chg_ok)
            chg_val = '0;
        sw = chg_ok && (seen_reg > SEEN_W'({p_reg, 1'b0}))
             && (((chg_val < 0) && (prev_chg_reg >= 0))
              || ((chg_val > 0) && (prev_chg_reg <= 0)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_reg        <= WIN_W'(WIN_RESET);
            wptr_reg       <= '0;
            seen_reg       <= '0;
            p_reg          <= WIN_W'(1);
            addr_reg       <= '0;
            iss_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            prev_reg       <= '0;
            now_reg        <= '0;
            old_reg        <= '0;
            sum_reg        <= '0;
            s_reg          <= '0;
            sq_prod_reg    <= '0;
            sq_vld_reg     <= 1'b0;
            sq_reg         <= '0;
            psq_reg        <= '0;
            ssq_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            neg_reg        <= 1'b0;
            root_reg       <= '0;
            inc_q_reg      <= '0;
            chg_q_reg      <= '0;
            prev_chg_reg   <= '0;
            swcnt_reg      <= '0;
            out_vld_reg    <= 1'b0;
            inc_out_reg    <= '0;
            inc_ok_out_reg <= 1'b0;
            chg_out_reg    <= '0;
            chg_ok_out_reg <= 1'b0;
            dev_out_reg    <= '0;
            dev_ok_out_reg <= 1'b0;
            sw_out_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                win_reg <= wr_data;
            end
            if (results.valid && results.ready && (state_reg != ST_OUT))
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wptr_reg   <= (wptr_reg == ADDR_W'(HIST_DEPTH - 1)) ? '0
                                                                            : wptr_reg + 1'b1;
                        seen_reg   <= (seen_reg == SEEN_W'(SEEN_MAX)) ? seen_reg
                                                                     : seen_reg + 1'b1;
                        p_reg      <= p_clamp;
                        addr_reg   <= wptr_reg;
                        iss_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        sq_vld_reg <= 1'b0;
                        sum_reg    <= '0;
                        s_reg      <= '0;
                        sq_reg     <= '0;
                        state_reg  <= ST_PASS;
                    end
                end
                ST_PASS:
                begin
                    // walk back from the newest sample, one read per cycle
                    if (iss_reg <= p_reg)
                    begin
                        addr_reg <= (addr_reg == '0) ? ADDR_W'(HIST_DEPTH - 1)
                                                     : addr_reg - 1'b1;
                        iss_reg  <= iss_reg + 1'b1;
                    end
                    rd_vld_reg <= (iss_reg <= p_reg);
                    rd_idx_reg <= iss_reg;
                    sq_vld_reg <= rd_vld_reg && (rd_idx_reg < p_reg);
                    if (rd_vld_reg)
                    begin
                        prev_reg <= rd_val;
                        if (rd_idx_reg == '0)
                            now_reg <= rd_val;
                        if (rd_idx_reg == p_reg)
                            old_reg <= rd_val;
                        if (rd_idx_reg < p_reg)
                        begin
                            s_reg       <= s_reg + S_W'(rd_val);
                            sq_prod_reg <= sq_now[SQ1_W-1:0];
                        end
                        if ((rd_idx_reg != '0) && (step_diff > 0))
                            sum_reg <= sum_reg + SUM_W'(step_diff[SAMPLE_W-1:0]);
                    end
                    if (sq_vld_reg)
                        sq_reg <= sq_reg + SQ_W'(sq_prod_reg);
                    if ((iss_reg > p_reg) && !rd_vld_reg && !sq_vld_reg)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    psq_reg   <= PSQ_W'(p_reg) * PSQ_W'(sq_reg);
                    ssq_reg   <= PSQ_W'(s_abs) * PSQ_W'(s_abs);
                    a_reg     <= A_W'(diff_abs) * A_W'(PCT_SCALE);
                    b_reg     <= old_reg[SAMPLE_W-1] ? SAMPLE_W'(-old_reg)
                                                     : SAMPLE_W'(old_reg);
                    neg_reg   <= chg_diff[SAMPLE_W] != old_reg[SAMPLE_W-1];
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        root_reg  <= sqrt_root;
                        state_reg <= ST_DIVI_GO;
                    end
                end
                ST_DIVI_GO:
                begin
                    state_reg <= ST_DIVI;
                end
                ST_DIVI:
                begin
                    if (div_done)
                    begin
                        inc_q_reg <= div_quo;
                        state_reg <= chg_ok ? ST_DIVC_GO : ST_DIVD_GO;
                    end
                end
                ST_DIVC_GO:
                begin
                    state_reg <= ST_DIVC;
                end
                ST_DIVC:
                begin
                    if (div_done)
                    begin
                        chg_q_reg <= div_quo;
                        state_reg <= ST_DIVD_GO;
                    end
                end
                ST_DIVD_GO:
                begin
                    state_reg <= ST_DIVD;
                end
                ST_DIVD:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_vld_reg || results.ready)
                    begin
                        out_vld_reg    <= 1'b1;
                        inc_out_reg    <= inc_ok ? inc_val : '0;
                        inc_ok_out_reg <= inc_ok;
                        chg_out_reg    <= chg_val;
                        chg_ok_out_reg <= chg_ok;
                        dev_out_reg    <= dev_ok ? dev_val : '0;
                        dev_ok_out_reg <= dev_ok;
                        sw_out_reg     <= sw;
                        if (chg_ok)
                            prev_chg_reg <= chg_val;
                        if (sw && (swcnt_reg != '1))
                            swcnt_reg <= swcnt_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign samples.ready           = (state_reg == ST_IDLE);
    assign results.valid           = out_vld_reg;
    assign results.increase_avg    = inc_out_reg;
    assign results.increase_valid  = inc_ok_out_reg;
    assign results.change_percent  = chg_out_reg;
    assign results.change_valid    = chg_ok_out_reg;
    assign results.deviation       = dev_out_reg;
    assign results.deviation_valid = dev_ok_out_reg;
    assign results.switch_now      = sw_out_reg;
    assign results.switch_total    = swcnt_reg;

`include "sliding_window_trend_stats_top_assert.svh"

    `SWTS_ASSERT(a_busy_after_accept, (samples.valid && samples.ready) |=> !samples.ready)
    `SWTS_ASSERT(a_switch_needs_change, (results.valid && results.switch_now) |-> results.change_valid)
    `SWTS_ASSERT(a_inc_implies_dev, (results.valid && results.increase_valid) |-> results.deviation_valid)
    `SWTS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !results.valid)
endmodule

// ----- src/swts_ram.sv -----
// generic single write port ram with registered read
module swts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/swts_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module swts_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swts_pkg::DIV_W-1:0]  dividend,
    input  logic [swts_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [swts_pkg::DIV_W-1:0]  quotient
);
    import swts_pkg::*;

    logic [DVS_W:0]     rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DVS_W:0]     shift_rem;
    logic [DVS_W:0]     sub_rem;
    logic               fits;

    always_comb
    begin
        shift_rem = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        sub_rem   = shift_rem - {1'b0, dvs_reg};
        fits      = shift_rem >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= DIV_CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? sub_rem : shift_rem;
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- src/swts_sqrt.sv -----
// iterative integer square root, one root bit per cycle
module swts_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swts_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [swts_pkg::ROOT_W-1:0] root
);
    import swts_pkg::*;

    logic [REM_W-1:0]      rem_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  fits;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            rad_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == SQRT_CNT_W'(1));
            if (start)
            begin
                rem_reg  <= '0;
                rad_reg  <= radicand;
                root_reg <= '0;
                cnt_reg  <= SQRT_CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
